FILE: design/smx_pkg.sv
package smx_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int ADDR_BITS_DEF   = 32;
    localparam int WORD_W          = 64;
    localparam int PC_W            = 32;
    localparam int OP_W            = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 8'd0,
        OP_AND  = 8'd1,
        OP_BIC  = 8'd2,
        OP_BEQ  = 8'd3,
        OP_BNE  = 8'd4,
        OP_BRA  = 8'd5,
        OP_DROP = 8'd6,
        OP_EOR  = 8'd7,
        OP_I8   = 8'd8,
        OP_I16  = 8'd9,
        OP_I32  = 8'd10,
        OP_ORR  = 8'd11,
        OP_POP  = 8'd12,
        OP_PUSH = 8'd13,
        OP_RSB  = 8'd14,
        OP_SUB  = 8'd15
    } opcode_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctl_t;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              branch_taken;
        logic [WORD_W-1:0] top_value;
    } result_t;

endpackage

FILE: design/smx_cell.sv
module smx_cell
    import smx_pkg::*;
(
    input  logic              aclk,
    input  stack_ctl_t        ctl,
    input  logic [WORD_W-1:0] from_above,
    input  logic [WORD_W-1:0] from_below,
    output logic [WORD_W-1:0] value
);

    logic [WORD_W-1:0] entry_reg;
    logic [WORD_W-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.push) begin
            entry_next = from_above;
        end else if (ctl.pop) begin
            entry_next = from_below;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign value = entry_reg;

endmodule

FILE: design/smx_exec.sv
module smx_exec
    import smx_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic              en,
    input  logic [OP_W-1:0]   opcode,
    input  logic [PC_W-1:0]   pc_after,
    input  logic [PC_W-1:0]   immediate,
    input  logic [WORD_W-1:0] top,
    input  logic [WORD_W-1:0] second,
    output stack_ctl_t        ctl,
    output logic [WORD_W-1:0] top_next,
    output result_t           result
);

    localparam logic [PC_W-1:0] PC_MASK =
        (ADDR_BITS >= PC_W) ? {PC_W{1'b1}} : ((PC_W'(1) << ADDR_BITS) - PC_W'(1));

    logic [PC_W-1:0] branch_pc;
    logic [PC_W-1:0] pc_raw;
    logic            taken;
    logic            do_push;
    logic            do_pop;

    assign branch_pc = pc_after + top[PC_W-1:0];

    always_comb begin
        top_next = top;
        pc_raw   = pc_after;
        taken    = 1'b0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        case (opcode)
            OP_ADD: begin
                do_pop   = 1'b1;
                top_next = top + second;
            end
            OP_AND: begin
                do_pop   = 1'b1;
                top_next = top & second;
            end
            OP_BIC: begin
                do_pop   = 1'b1;
                top_next = top & ~second;
            end
            OP_BEQ: begin
                do_pop = 1'b1;
                if (second == '0) begin
                    pc_raw = branch_pc;
                    taken  = 1'b1;
                end
            end
            OP_BNE: begin
                do_pop = 1'b1;
                if (second != '0) begin
                    pc_raw = branch_pc;
                    taken  = 1'b1;
                end
            end
            OP_BRA: begin
                pc_raw = branch_pc;
                taken  = 1'b1;
            end
            OP_DROP: begin
                do_pop = 1'b1;
            end
            OP_EOR: begin
                do_pop   = 1'b1;
                top_next = top ^ second;
            end
            OP_I8: begin
                top_next = {{(WORD_W-8){1'b0}}, immediate[7:0]};
                pc_raw   = pc_after + PC_W'(1);
            end
            OP_I16: begin
                top_next = {{(WORD_W-16){1'b0}}, immediate[15:0]};
                pc_raw   = pc_after + PC_W'(2);
            end
            OP_I32: begin
                top_next = {{(WORD_W-PC_W){1'b0}}, immediate};
                pc_raw   = pc_after + PC_W'(4);
            end
            OP_ORR: begin
                do_pop   = 1'b1;
                top_next = top | second;
            end
            OP_POP: begin
                do_pop   = 1'b1;
                top_next = second;
            end
            OP_PUSH: begin
                do_push = 1'b1;
            end
            OP_RSB: begin
                do_pop   = 1'b1;
                top_next = second - top;
            end
            OP_SUB: begin
                do_pop   = 1'b1;
                top_next = top - second;
            end
            default: begin
            end
        endcase
    end

    assign ctl.push = en & do_push;
    assign ctl.pop  = en & do_pop;

    assign result.next_pc      = pc_raw & PC_MASK;
    assign result.branch_taken = taken;
    assign result.top_value    = top_next;

endmodule

FILE: design/smx_outq.sv
module smx_outq
    import smx_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t    slot0_reg;
    result_t    slot0_next;
    result_t    slot1_reg;
    result_t    slot1_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] wpos;
    logic       wr;
    logic       rd;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;
    assign wr        = in_valid & in_ready;
    assign rd        = out_valid & out_ready;
    assign wpos      = count_reg - 2'(rd);

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg + 2'(wr) - 2'(rd);
        if (rd) begin
            slot0_next = slot1_reg;
        end
        if (wr) begin
            if (wpos == 2'd0) begin
                slot0_next = in_data;
            end else begin
                slot1_next = in_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

FILE: design/stack_machine_execute_unit_top.sv
// Stack machine execute unit: one instruction per item, one item per clock while
// s_ready is high; each result is registered in an output queue. The top of stack
// sits in a register and the stack below it is a ring of STACK_DEPTH cells that
// rotates by one cell on each push or pop, so the second operand is always cell 0
// and back-to-back instructions see each other's results with no hazard. A two-item
// output queue keeps s_ready high while one result waits on m_ready; s_ready drops
// only when two results are pending. Stack entries that were never pushed read as
// unknown values.
module stack_machine_execute_unit_top
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_opcode,
    input  logic [PC_W-1:0]          s_pc_after,
    input  logic [PC_W-1:0]          s_immediate,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [PC_W-1:0]          m_next_pc,
    output logic                     m_branch_taken,
    output logic signed [WORD_W-1:0] m_top_value
);

    logic [WORD_W-1:0] top_reg;
    logic [WORD_W-1:0] top_next;
    logic [WORD_W-1:0] cell_value [STACK_DEPTH];
    logic              accept;
    stack_ctl_t        ctl;
    result_t           exec_result;
    result_t           out_result;

    assign accept = s_valid & s_ready;

    smx_exec #(
        .ADDR_BITS (ADDR_BITS)
    ) u_exec (
        .en        (accept),
        .opcode    (s_opcode),
        .pc_after  (s_pc_after),
        .immediate (s_immediate),
        .top       (top_reg),
        .second    (cell_value[0]),
        .ctl       (ctl),
        .top_next  (top_next),
        .result    (exec_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg <= '0;
        end else if (accept) begin
            top_reg <= top_next;
        end
    end

    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        logic [WORD_W-1:0] above;
        logic [WORD_W-1:0] below;

        if (k == 0) begin : g_head
            assign above = top_reg;
        end else begin : g_body
            assign above = cell_value[k-1];
        end

        if (k == STACK_DEPTH - 1) begin : g_tail
            assign below = cell_value[0];
        end else begin : g_link
            assign below = cell_value[k+1];
        end

        smx_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .from_above (above),
            .from_below (below),
            .value      (cell_value[k])
        );
    end

    smx_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (exec_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_next_pc      = out_result.next_pc;
    assign m_branch_taken = out_result.branch_taken;
    assign m_top_value    = signed'(out_result.top_value);

endmodule
